### rtl/lrpt_pkg.sv
// shared types and constants for the longest received prefix tracker
package lrpt_pkg;

    localparam int ITEM_W         = 11;
    localparam int DEF_MAX_ITEMS  = 1024;
    localparam int DEF_WORD_BITS  = 64;
    localparam int PDATA_W        = 32;
    localparam int PADDR_W        = 3;

    localparam logic [ITEM_W-1:0] ITEM_COUNT_RESET = 11'd1024;

    // register select is paddr[2], one register per 32-bit slot
    localparam logic REG_ITEM_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_SCAN,
        ST_WAIT
    } lrpt_state_t;

endpackage

### rtl/longest_received_prefix_tracker.sv
// Longest received prefix tracker: takes one-based item numbers and returns, for each word
// taken, the length of the longest run 1..P of received items plus an out-of-range flag.
// The received bitmap lives in one synchronous memory of NUM_WORDS words (16 with defaults);
// after reset a clearing pass writes zeros over all NUM_WORDS words of it, one word per cycle,
// with item_stall held high (configuration writes still go through). An out-of-range item is
// answered from the idle state, through the wait state if the output is stalled. An in-range
// item takes these steps in order: read the item's word, write it back while the word at the
// prefix pointer is read, then one find-first-zero step per bitmap word scanned. The
// scan is bounded by the single memory port and advances at most one word per cycle. One
// result may wait in the output register while the next word is taken.
module longest_received_prefix_tracker
    import lrpt_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS,
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [ITEM_W-1:0]   item_number,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output logic [ITEM_W-1:0]   prefix_length,
    output logic                out_of_range,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // memory word width rounded down to a power of two
    localparam int LOGW      = $clog2(WORD_BITS + 1) - 1;
    localparam int PW        = 1 << LOGW;
    localparam int NUM_WORDS = (MAX_ITEMS + PW - 1) / PW;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CAND_W    = (AW + LOGW + 1 > ITEM_W + 1) ? AW + LOGW + 1 : ITEM_W + 1;
    localparam int CAP       = (MAX_ITEMS > (1 << ITEM_W) - 1) ? (1 << ITEM_W) - 1 : MAX_ITEMS;
    localparam logic [ITEM_W-1:0] CAP_V    = ITEM_W'(CAP);
    localparam logic [AW-1:0]     LAST_ADR = AW'(NUM_WORDS - 1);

    lrpt_state_t state_reg, state_next;

    logic [ITEM_W-1:0] item_count_reg, item_count_next;
    logic [ITEM_W-1:0] ptr_reg, ptr_next;
    logic              flag_reg, flag_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [AW-1:0]     set_addr_reg, set_addr_next;
    logic [LOGW-1:0]   set_bit_reg, set_bit_next;
    logic              fwd_reg, fwd_next;
    logic [PW-1:0]     fwd_data_reg, fwd_data_next;
    logic              result_valid_reg, result_valid_next;
    logic [ITEM_W-1:0] prefix_length_reg, prefix_length_next;
    logic              out_of_range_reg, out_of_range_next;

    logic [PW-1:0]     mem [NUM_WORDS];
    logic [PW-1:0]     rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [PW-1:0]     mem_wdata;

    logic              item_accept;
    logic              cfg_write;
    logic [ITEM_W-1:0] count_eff;
    logic              oor;
    logic [CAND_W-1:0] num_m1;
    logic [CAND_W-1:0] ptr_ext;
    logic [CAND_W-1:0] count_ext;
    logic [AW-1:0]     ptr_word;
    logic [PW-1:0]     set_word;
    logic [PW-1:0]     scan_word;
    logic [PW-1:0]     scan_masked;
    logic              scan_full;
    logic [CAND_W-1:0] scan_base;
    logic [CAND_W-1:0] scan_cand;
    logic [CAND_W-1:0] ptr_new_ext;
    logic              scan_done;
    logic [ITEM_W-1:0] ptr_new;
    logic              load_ok;
    logic              res_load;
    logic [ITEM_W-1:0] res_len;
    logic              res_flag;

    function automatic logic [LOGW-1:0] first_zero(input logic [PW-1:0] v);
        logic [LOGW-1:0] r;
        r = '0;
        for (int i = PW - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r = LOGW'(i);
            end
        end
        return r;
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ITEM_COUNT) ? PDATA_W'(item_count_reg) : '0;

    always_comb
    begin
        item_count_next = item_count_reg;
        if (cfg_write && paddr[2] == REG_ITEM_COUNT)
        begin
            item_count_next = pwdata[ITEM_W-1:0];
        end
    end

    // item decode
    assign item_accept = item_valid && !item_stall;
    assign count_eff   = (item_count_reg > CAP_V) ? CAP_V : item_count_reg;
    assign oor         = (item_number == '0) || (item_number > count_eff);
    assign num_m1      = CAND_W'(item_number) - CAND_W'(1);
    assign ptr_ext     = CAND_W'(ptr_reg);
    assign count_ext   = CAND_W'(count_eff);
    assign ptr_word    = ptr_ext[LOGW +: AW];
    assign set_word    = rdata_reg | (PW'(1) << set_bit_reg);

    // find-first-zero over one bitmap word, starting at the pointer's bit offset
    assign scan_word   = fwd_reg ? fwd_data_reg : rdata_reg;
    assign scan_masked = scan_word | ((PW'(1) << ptr_reg[LOGW-1:0]) - PW'(1));
    assign scan_full   = &scan_masked;
    assign scan_base   = {ptr_ext[CAND_W-1:LOGW], LOGW'(0)};
    assign scan_cand   = scan_full ? scan_base + CAND_W'(PW)
                                   : scan_base + CAND_W'(first_zero(scan_masked));

    always_comb
    begin
        if (ptr_ext >= count_ext)
        begin
            ptr_new_ext = ptr_ext;
            scan_done   = 1'b1;
        end
        else if (scan_cand >= count_ext)
        begin
            ptr_new_ext = count_ext;
            scan_done   = 1'b1;
        end
        else
        begin
            ptr_new_ext = scan_cand;
            scan_done   = !scan_full;
        end
    end

    assign ptr_new = ptr_new_ext[ITEM_W-1:0];

    // result hand-off
    assign load_ok = !result_valid_reg || !result_stall;

    always_comb
    begin
        res_load = 1'b0;
        res_len  = ptr_reg;
        res_flag = flag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                res_load = item_accept && oor && load_ok;
                res_flag = 1'b1;
            end
            ST_SCAN:
            begin
                res_load = scan_done && load_ok;
                res_len  = ptr_new;
                res_flag = 1'b0;
            end
            ST_WAIT:
            begin
                res_load = load_ok;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (!oor)
                    begin
                        state_next = ST_SET;
                    end
                    else if (!load_ok)
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_SET:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = load_ok ? ST_IDLE : ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (load_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory control and stall
    always_comb
    begin
        item_stall = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = set_addr_reg;
        mem_wdata  = set_word;
        mem_raddr  = ptr_word;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                item_stall = 1'b0;
                mem_raddr  = num_m1[LOGW +: AW];
            end
            ST_SET:
            begin
                // write back the item's word while the pointer's word is read
                mem_we = 1'b1;
            end
            ST_SCAN:
            begin
                mem_raddr = scan_cand[LOGW +: AW];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // datapath register updates
    always_comb
    begin
        ptr_next           = ptr_reg;
        flag_next          = flag_reg;
        clr_addr_next      = clr_addr_reg;
        set_addr_next      = set_addr_reg;
        set_bit_next       = set_bit_reg;
        fwd_next           = 1'b0;
        fwd_data_next      = fwd_data_reg;
        result_valid_next  = result_valid_reg;
        prefix_length_next = prefix_length_reg;
        out_of_range_next  = out_of_range_reg;

        if (state_reg == ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end
        if (state_reg == ST_IDLE && item_accept)
        begin
            flag_next     = oor;
            set_addr_next = num_m1[LOGW +: AW];
            set_bit_next  = num_m1[LOGW-1:0];
        end
        if (state_reg == ST_SET)
        begin
            // read and write of the same word cross in this cycle
            fwd_next      = (ptr_word == set_addr_reg);
            fwd_data_next = set_word;
        end
        if (state_reg == ST_SCAN)
        begin
            ptr_next = ptr_new;
        end

        if (res_load)
        begin
            result_valid_next  = 1'b1;
            prefix_length_next = res_len;
            out_of_range_next  = res_flag;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            item_count_reg   <= ITEM_COUNT_RESET;
            ptr_reg          <= '0;
            flag_reg         <= 1'b0;
            clr_addr_reg     <= '0;
            fwd_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            item_count_reg   <= item_count_next;
            ptr_reg          <= ptr_next;
            flag_reg         <= flag_next;
            clr_addr_reg     <= clr_addr_next;
            fwd_reg          <= fwd_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_addr_reg      <= set_addr_next;
        set_bit_reg       <= set_bit_next;
        fwd_data_reg      <= fwd_data_next;
        prefix_length_reg <= prefix_length_next;
        out_of_range_reg  <= out_of_range_next;
    end

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign result_valid  = result_valid_reg;
    assign prefix_length = prefix_length_reg;
    assign out_of_range  = out_of_range_reg;

    // the prefix only grows
    assert property (@(posedge clk) disable iff (!rst_n) ptr_reg >= $past(ptr_reg))
        else $error("prefix pointer moved backward");

    // the prefix never passes the largest usable count
    assert property (@(posedge clk) disable iff (!rst_n) ptr_reg <= CAP_V)
        else $error("prefix pointer beyond item capacity");

    // an in-range word always starts a bitmap update
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && !oor) |=> (state_reg == ST_SET))
        else $error("in-range word did not start an update");

    // a finished result is never dropped while the output register is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && !load_ok) |=> (state_reg == ST_WAIT))
        else $error("pending result lost");

endmodule

### tb/tb_longest_received_prefix_tracker.sv
// testbench for the longest received prefix tracker: directed and random item streams
`timescale 1ns / 1ps

module tb_longest_received_prefix_tracker
    import lrpt_pkg::*;
();

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int WINDOW_TARGET = 560;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_LIMIT     = (1 << ITEM_W) - 1;
    localparam logic [PADDR_W-1:0] ADDR_ITEM_COUNT = {REG_ITEM_COUNT, 2'b00};

    typedef struct packed {
        logic [ITEM_W-1:0] prefix;
        logic              oor;
    } prefix_result_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic [ITEM_W-1:0]   item_number;
    logic                result_valid;
    logic                result_stall;
    logic [ITEM_W-1:0]   prefix_length;
    logic                out_of_range;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // tracker shadow state
    bit [DEF_MAX_ITEMS-1:0] seen_items;
    int                     prefix_ptr;
    logic [ITEM_W-1:0]      count_reg;
    prefix_result_t         pending_results[$];

    int  cycle_count;
    int  mismatches;
    int  items_sent;
    int  rejected_sent;
    int  count_writes;
    int  window_sent;
    int  hold_left;
    bit  item_gaps_on;
    bit  result_stalls_on;
    prefix_result_t got_want;

    longest_received_prefix_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item_number   (item_number),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .prefix_length (prefix_length),
        .out_of_range  (out_of_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic prefix_result_t track_item(input logic [ITEM_W-1:0] num);
        prefix_result_t res;
        int limit;
        limit = (count_reg > DEF_MAX_ITEMS) ? DEF_MAX_ITEMS : int'(count_reg);
        res.oor = 1'b0;
        if (num == 0 || num > limit)
            res.oor = 1'b1;
        else
        begin
            seen_items[num - 1] = 1'b1;
            while (prefix_ptr < limit && seen_items[prefix_ptr])
                prefix_ptr++;
        end
        res.prefix = prefix_ptr[ITEM_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatches < 10)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // receiver side: random stalls plus an optional long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (result_stalls_on && $urandom_range(0, 99) < 30)
            begin
                stall_left = pick_gap();
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, prefix_length", -1,
                                prefix_length);
            else
            begin
                got_want = pending_results.pop_front();
                if (prefix_length !== got_want.prefix)
                    report_mismatch("prefix_length", got_want.prefix, prefix_length);
                if (out_of_range !== got_want.oor)
                    report_mismatch("out_of_range", got_want.oor, out_of_range);
            end
        end
    end

    task automatic send_item(input logic [ITEM_W-1:0] num);
        prefix_result_t res;
        int gap;
        gap = item_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        item_number <= num;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        res = track_item(num);
        pending_results = {pending_results, res};
        items_sent++;
        if (res.oor)
            rejected_sent++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_item_count(input logic [ITEM_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ITEM_COUNT;
        // upper bits are junk, the register keeps only the low bits
        pwdata  <= {(PDATA_W - ITEM_W)'($urandom_range(0, (1 << (PDATA_W - ITEM_W)) - 1)),
                    value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_reg = value;
        count_writes++;
    endtask

    task automatic test_rejected_numbers();
        send_item('0);
        send_item(NUM_LIMIT[ITEM_W-1:0]);
        send_item(ITEM_W'(DEF_MAX_ITEMS + 1));
        send_item(ITEM_W'(DEF_MAX_ITEMS));
    endtask

    task automatic test_prefix_order();
        send_item(ITEM_W'(1));
        send_item(ITEM_W'(1));
        send_item(ITEM_W'(3));
        send_item(ITEM_W'(2));
        send_item(ITEM_W'(5));
    endtask

    task automatic test_count_extremes();
        write_item_count('0);
        send_item(ITEM_W'(4));
        send_item('0);
        // oversized count acts as the full bitmap
        write_item_count(NUM_LIMIT[ITEM_W-1:0]);
        send_item(ITEM_W'(DEF_MAX_ITEMS));
        send_item(ITEM_W'(4));
        // shrink below the pointer, which must hold its place
        write_item_count(ITEM_W'(2));
        send_item(ITEM_W'(3));
        send_item(ITEM_W'(2));
        write_item_count(ITEM_W'(1));
        send_item(ITEM_W'(1));
        send_item(ITEM_W'(2));
        write_item_count(ITEM_W'(DEF_MAX_ITEMS));
    endtask

    task automatic test_backpressure();
        int n;
        drain_results();
        item_gaps_on = 1'b0;
        hold_left = HOLD_CYCLES;
        for (n = 0; n < 40 && prefix_ptr + n < DEF_MAX_ITEMS; n++)
            send_item(ITEM_W'(prefix_ptr + 1 + ((n + 1) % 40)));
        item_gaps_on = 1'b1;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: send_item('0);
            1: send_item(ITEM_W'($urandom_range(DEF_MAX_ITEMS + 1, NUM_LIMIT)));
            2: send_item(ITEM_W'($urandom_range(0, NUM_LIMIT)));
            3: send_item(ITEM_W'(prefix_ptr > 0 ? $urandom_range(1, prefix_ptr) : 0));
            default:
                send_item(ITEM_W'(prefix_ptr < DEF_MAX_ITEMS ?
                                  $urandom_range(prefix_ptr + 1, DEF_MAX_ITEMS) : 0));
        endcase
    endtask

    task automatic test_random_windows();
        int window[$];
        int span;
        int mode;
        int i;
        int j;
        int tmp;
        while (window_sent < WINDOW_TARGET && prefix_ptr < DEF_MAX_ITEMS)
        begin
            span = $urandom_range(4, 64);
            if (span > DEF_MAX_ITEMS - prefix_ptr)
                span = DEF_MAX_ITEMS - prefix_ptr;
            mode = $urandom_range(0, 9);
            if (mode < 4)
                write_item_count(ITEM_W'(DEF_MAX_ITEMS));
            else if (mode < 6)
                write_item_count(ITEM_W'($urandom_range(DEF_MAX_ITEMS + 1, NUM_LIMIT)));
            else if (mode < 9)
                write_item_count(ITEM_W'(prefix_ptr + $urandom_range(1, span)));
            else
            begin
                write_item_count(ITEM_W'($urandom_range(0, prefix_ptr)));
                span = (span > 4) ? 4 : span;
            end
            item_gaps_on     = ($urandom_range(0, 3) != 0);
            result_stalls_on = ($urandom_range(0, 3) != 0);
            window.delete();
            for (i = 1; i <= span; i++)
                window = {window, prefix_ptr + i};
            for (i = span - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = window[i];
                window[i] = window[j];
                window[j] = tmp;
            end
            while (window.size() != 0)
            begin
                if ($urandom_range(0, 99) < 25)
                    send_noise();
                else
                begin
                    send_item(ITEM_W'(window.pop_front()));
                    window_sent++;
                end
            end
        end
        item_gaps_on     = 1'b1;
        result_stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item_number  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        cycle_count  = 0;
        mismatches   = 0;
        items_sent   = 0;
        rejected_sent = 0;
        count_writes = 0;
        window_sent  = 0;
        hold_left    = 0;
        seen_items   = '0;
        prefix_ptr   = 0;
        count_reg    = ITEM_COUNT_RESET;
        item_gaps_on     = 1'b1;
        result_stalls_on = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_rejected_numbers();
        test_prefix_order();
        test_count_extremes();
        test_backpressure();
        test_random_windows();

        drain_results();
        $display("%0d words sent, %0d out of range, %0d item_count writes",
                 items_sent, rejected_sent, count_writes);
        $display("final prefix %0d, %0d mismatches", prefix_ptr, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
